// ----- rtl/png_chunk_framer_crc32_assert.svh -----
// Assertion macros for the PNG chunk framer RTL.
// Included by modules that carry concurrent checks; no dependencies.
`ifndef PNG_CHUNK_FRAMER_CRC32_ASSERT_SVH
`define PNG_CHUNK_FRAMER_CRC32_ASSERT_SVH

// same-cycle implication
`define PCF_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcf: same-cycle check failed");

// next-cycle implication
`define PCF_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcf: next-cycle check failed");

`endif

// ----- rtl/pcf_pkg.sv -----
// Shared types, constants and the CRC-32 byte step for the PNG chunk framer.
// No dependencies.
package pcf_pkg;

    localparam int LEN_W           = 31;
    localparam int TYPE_W          = 32;
    localparam int BYTE_W          = 8;
    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int STEP_W          = 4;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    localparam logic [STEP_W-1:0] FIRST_STEP = 4'd0;
    localparam logic [STEP_W-1:0] TYPE_STEP  = 4'd4;
    localparam logic [STEP_W-1:0] DATA_STEP  = 4'd7;
    localparam logic [STEP_W-1:0] LAST_STEP  = 4'd11;

    typedef enum logic {
        CMD_BEGIN = 1'b0,
        CMD_DATA  = 1'b1
    } cmd_kind_t;

    typedef enum logic [1:0] {
        SEC_LENGTH = 2'd0,
        SEC_TYPE   = 2'd1,
        SEC_DATA   = 2'd2,
        SEC_CRC    = 2'd3
    } section_t;

    typedef enum logic [1:0] {
        SEG_LENGTH = 2'd0,
        SEG_BODY   = 2'd1,
        SEG_CRC    = 2'd2,
        SEG_NONE   = 2'd3
    } segment_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic               crc_follows;
        logic [LEN_W-1:0]   length;
        logic [TYPE_W-1:0]  word;
    } cmd_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in,
                                             input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/pcf_front.sv -----
// Front end: accepts input transactions, tracks the open chunk and issues commands.
// Depends on pcf_pkg.
module pcf_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       func,
    input  logic [pcf_pkg::LEN_W-1:0]  chunk_length,
    input  logic [pcf_pkg::TYPE_W-1:0] chunk_type,
    input  logic [pcf_pkg::BYTE_W-1:0] data_byte,
    input  logic                       q_full,
    output logic                       q_wr,
    output pcf_pkg::cmd_t              q_cmd
);
    import pcf_pkg::*;

    logic             open_reg, open_next;
    logic [LEN_W-1:0] remain_reg, remain_next;
    logic [LEN_W-1:0] remain_dec;
    logic             accept;

    assign full       = q_full;
    assign accept     = push && !q_full;
    assign remain_dec = remain_reg - LEN_W'(1);

    always_comb
    begin
        open_next   = open_reg;
        remain_next = remain_reg;
        q_wr        = 1'b0;
        q_cmd       = '{kind: CMD_BEGIN, crc_follows: 1'b0,
                        length: chunk_length, word: chunk_type};
        if (accept)
        begin
            if (func == 1'b0)
            begin
                q_wr              = 1'b1;
                q_cmd.crc_follows = (chunk_length == '0);
                open_next         = (chunk_length != '0);
                remain_next       = chunk_length;
            end
            else if (open_reg)
            begin
                q_wr              = 1'b1;
                q_cmd.kind        = CMD_DATA;
                q_cmd.word        = {{(TYPE_W-BYTE_W){1'b0}}, data_byte};
                q_cmd.crc_follows = (remain_dec == '0);
                open_next         = (remain_dec != '0);
                remain_next       = remain_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= 1'b0;
            remain_reg <= '0;
        end
        else
        begin
            open_reg   <= open_next;
            remain_reg <= remain_next;
        end
    end

endmodule

// ----- rtl/pcf_cmd_queue.sv -----
// Small register-based FIFO of commands between front and back ends.
// Depends on pcf_pkg.
module pcf_cmd_queue #(
    parameter int DEPTH = pcf_pkg::CMD_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  pcf_pkg::cmd_t wr_cmd,
    output logic          q_full,
    input  logic          rd,
    output logic          q_empty,
    output pcf_pkg::cmd_t rd_cmd
);
    import pcf_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t           mem_reg [DEPTH];
    logic [IDX_W:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W:0] rd_ptr_reg, rd_ptr_next;

    assign q_empty = (wr_ptr_reg == rd_ptr_reg);
    assign q_full  = (wr_ptr_reg[IDX_W] != rd_ptr_reg[IDX_W]) &&
                     (wr_ptr_reg[IDX_W-1:0] == rd_ptr_reg[IDX_W-1:0]);
    assign rd_cmd  = mem_reg[rd_ptr_reg[IDX_W-1:0]];

    assign wr_ptr_next = wr_ptr_reg + (IDX_W+1)'(1);
    assign rd_ptr_next = rd_ptr_reg + (IDX_W+1)'(1);

    always_ff @(posedge clk)
    begin
        if (wr && !q_full)
        begin
            mem_reg[wr_ptr_reg[IDX_W-1:0]] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (wr && !q_full)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (rd && !q_empty)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

endmodule

// ----- rtl/pcf_back.sv -----
// Back end: sequences chunk bytes, runs the CRC-32 and holds the result register.
// Depends on pcf_pkg and png_chunk_framer_crc32_assert.svh.
module pcf_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  pcf_pkg::cmd_t              q_cmd,
    output logic                       q_rd,
    output logic                       empty,
    input  logic                       pop,
    output logic [pcf_pkg::BYTE_W-1:0] out_byte,
    output logic [1:0]                 section,
    output logic                       chunk_end,
    output logic                       item_last
);
    import pcf_pkg::*;
    `include "png_chunk_framer_crc32_assert.svh"

    logic              cur_valid_reg;
    cmd_t              cur_cmd_reg;
    logic [STEP_W-1:0] step_reg;
    logic [31:0]       crc_reg;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    section_t          section_reg;
    logic              chunk_end_reg;
    logic              item_last_reg;

    logic              advance, emit, last_step, load;
    segment_t          seg;
    logic [31:0]       src_word;
    logic [1:0]        lane;
    logic [BYTE_W-1:0] cur_byte;
    section_t          cur_sec;
    logic [31:0]       crc_in;

    assign advance   = !out_valid_reg || pop;
    assign emit      = cur_valid_reg && advance;
    assign last_step = (step_reg == DATA_STEP && !cur_cmd_reg.crc_follows) ||
                       (step_reg == LAST_STEP);
    assign load      = !q_empty && (!cur_valid_reg || (emit && last_step));
    assign q_rd      = load;

    assign seg  = segment_t'(step_reg[3:2]);
    assign lane = 2'd3 - step_reg[1:0];

    always_comb
    begin
        case (seg)
            SEG_LENGTH: src_word = {1'b0, cur_cmd_reg.length};
            SEG_BODY:   src_word = cur_cmd_reg.word;
            SEG_CRC:    src_word = crc_reg ^ CRC_ONES;
            default:    src_word = crc_reg ^ CRC_ONES;
        endcase
    end

    always_comb
    begin
        if (cur_cmd_reg.kind == CMD_DATA && seg == SEG_BODY)
        begin
            cur_byte = cur_cmd_reg.word[BYTE_W-1:0];
        end
        else
        begin
            cur_byte = src_word[{lane, 3'b000} +: BYTE_W];
        end
    end

    always_comb
    begin
        case (seg)
            SEG_LENGTH: cur_sec = SEC_LENGTH;
            SEG_BODY:   cur_sec = (cur_cmd_reg.kind == CMD_DATA) ? SEC_DATA : SEC_TYPE;
            SEG_CRC:    cur_sec = SEC_CRC;
            default:    cur_sec = SEC_CRC;
        endcase
    end

    assign crc_in = (cur_cmd_reg.kind == CMD_BEGIN && step_reg == TYPE_STEP) ?
                    CRC_ONES : crc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= FIRST_STEP;
            crc_reg       <= CRC_ONES;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                cur_valid_reg <= 1'b1;
                step_reg      <= (q_cmd.kind == CMD_DATA) ? DATA_STEP : FIRST_STEP;
            end
            else if (emit)
            begin
                cur_valid_reg <= !last_step;
                step_reg      <= step_reg + STEP_W'(1);
            end
            if (emit && seg == SEG_BODY)
            begin
                crc_reg <= crc_byte(crc_in, cur_byte);
            end
            if (advance)
            begin
                out_valid_reg <= cur_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_cmd_reg <= q_cmd;
        end
        if (emit)
        begin
            out_byte_reg  <= cur_byte;
            section_reg   <= cur_sec;
            chunk_end_reg <= (step_reg == LAST_STEP);
            item_last_reg <= last_step;
        end
    end

    assign empty     = !out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign section   = section_reg;
    assign chunk_end = chunk_end_reg;
    assign item_last = item_last_reg;

    `PCF_ASSERT_IMP(a_step_range, clk, rst_n, cur_valid_reg, step_reg <= LAST_STEP)
    `PCF_ASSERT_IMP(a_data_step, clk, rst_n, cur_valid_reg && cur_cmd_reg.kind == CMD_DATA,
                    step_reg >= DATA_STEP)
    `PCF_ASSERT_IMP(a_end_is_last, clk, rst_n, out_valid_reg && chunk_end_reg,
                    item_last_reg && section_reg == SEC_CRC)
    `PCF_ASSERT_NXT(a_keep_busy, clk, rst_n, emit && !last_step, cur_valid_reg)

endmodule

// ----- rtl/png_chunk_framer_crc32.sv -----
// PNG chunk framer with CRC-32, top level.
// Depends on pcf_pkg, pcf_front, pcf_cmd_queue and pcf_back.
//
// Input queue port (push/full): func=0 begins a chunk from chunk_length and
// chunk_type, func=1 carries one data_byte. Output queue port (empty/pop):
// one byte of the chunk stream per transaction with its section, chunk_end
// on the last CRC byte and item_last on the last byte of an input transaction.
// Data bytes with no chunk open produce nothing.
// Path: an accepted transaction is written into the command queue, loaded into
// the back end's current command register, and each byte is registered into
// the output register. Throughput: the back end emits one byte per cycle while
// its output byte is popped or empty; a data transaction yields 1 byte, the last
// one 5, a begin 8 and a zero-length begin 12. The command queue
// (CMD_QUEUE_DEPTH entries) absorbs input while a header or trailer is being sent.
// Reset: asynchronous, clears the open chunk, the queue and the output.
// Stall: while the output byte is not popped the back end holds it; the
// front end keeps accepting until the command queue fills, then raises full.
module png_chunk_framer_crc32 #(
    parameter int CMD_QUEUE_DEPTH = pcf_pkg::CMD_QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       func,
    input  logic [pcf_pkg::LEN_W-1:0]  chunk_length,
    input  logic [pcf_pkg::TYPE_W-1:0] chunk_type,
    input  logic [pcf_pkg::BYTE_W-1:0] data_byte,
    output logic                       empty,
    input  logic                       pop,
    output logic [pcf_pkg::BYTE_W-1:0] out_byte,
    output logic [1:0]                 section,
    output logic                       chunk_end,
    output logic                       item_last
);
    import pcf_pkg::*;

    logic q_full, q_empty, q_wr, q_rd;
    cmd_t wr_cmd, rd_cmd;

    pcf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .func         (func),
        .chunk_length (chunk_length),
        .chunk_type   (chunk_type),
        .data_byte    (data_byte),
        .q_full       (q_full),
        .q_wr         (q_wr),
        .q_cmd        (wr_cmd)
    );

    pcf_cmd_queue #(
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_cmd  (wr_cmd),
        .q_full  (q_full),
        .rd      (q_rd),
        .q_empty (q_empty),
        .rd_cmd  (rd_cmd)
    );

    pcf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cmd     (rd_cmd),
        .q_rd      (q_rd),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .section   (section),
        .chunk_end (chunk_end),
        .item_last (item_last)
    );

endmodule
